@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its antecedent.
`define SB64_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Property holds in the cycle after its antecedent.
`define SB64_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/sb64_pkg.sv @@
// Types, codes and character helpers of the strict base64 decoder.
package sb64_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] MAX_OUTPUT_RESET = 32'd536870912;

   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NON_ASCII = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
   localparam logic [2:0] STATUS_MALFORMED = 3'd4;

   localparam logic [15:0] CHAR_PAD = 16'h003D;

   typedef struct packed {
      logic        action;
      logic [15:0] code_unit;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // One queued job: up to three bytes (first at top) or one status.
   typedef struct packed {
      logic        is_status;
      logic [1:0]  nbytes;
      logic [23:0] bytes;
      logic [2:0]  status;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   function automatic logic is_space(input logic [15:0] u);
      logic r;
      r = (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
          u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
          u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
          u == 16'h3000;
      return r;
   endfunction

   // {valid, sextet}; valid is low outside the alphabet.
   function automatic logic [6:0] sextet_of(input logic [15:0] u);
      logic [6:0] r;
      r = 7'd0;
      if (u >= 16'h0041 && u <= 16'h005A)
         r = {1'b1, 6'(u - 16'h0041)};
      else if (u >= 16'h0061 && u <= 16'h007A)
         r = {1'b1, 6'(u - 16'h0061 + 16'd26)};
      else if (u >= 16'h0030 && u <= 16'h0039)
         r = {1'b1, 6'(u - 16'h0030 + 16'd52)};
      else if (u == 16'h002B)
         r = {1'b1, 6'd62};
      else if (u == 16'h002F)
         r = {1'b1, 6'd63};
      return r;
   endfunction

endpackage

@@ rtl/sb64_front.sv @@
// Front end: accepts characters, tracks quartet state and pushes jobs.
module sb64_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   input  logic                  accept,
   input  sb64_pkg::req_type     req,
   output sb64_pkg::job_push_type push
);

   logic [31:0] max_ff;
   logic [17:0] held_ff, held_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pad_ff, pad_in;
   logic        pdone_ff, pdone_in;
   logic        nasc_ff, nasc_in;
   logic        mal_ff, mal_in;
   logic [32:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= sb64_pkg::MAX_OUTPUT_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   always_comb begin
      logic [15:0] u;
      logic [6:0]  sx;
      logic [5:0]  s, a, b, c;
      logic        is_pad, pad3;
      logic [33:0] sum, diff;
      logic [1:0]  pad_len;
      logic [2:0]  st;

      u      = req.code_unit;
      sx     = sb64_pkg::sextet_of(u);
      s      = sx[5:0];
      is_pad = (u == sb64_pkg::CHAR_PAD);
      a      = held_ff[17:12];
      b      = held_ff[11:6];
      c      = held_ff[5:0];
      pad3   = pad_ff[0];
      sum    = {1'b0, count_ff} + 34'd3;
      pad_len = pad_ff[1] ? (pad_ff[0] ? 2'd2 : 2'd1) : 2'd0;
      diff   = {1'b0, count_ff} - {32'd0, pad_len};

      held_in  = held_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      pdone_in = pdone_ff;
      nasc_in  = nasc_ff;
      mal_in   = mal_ff;
      count_in = count_ff;
      push     = '0;

      if (req.action == sb64_pkg::ACT_END) begin
         if (nasc_ff)
            st = sb64_pkg::STATUS_NON_ASCII;
         else if (pos_ff != 2'd0)
            st = sb64_pkg::STATUS_BAD_LEN;
         else if (diff > {2'b00, max_ff})
            st = sb64_pkg::STATUS_TOO_LARGE;
         else if (mal_ff)
            st = sb64_pkg::STATUS_MALFORMED;
         else
            st = sb64_pkg::STATUS_OK;
         push.valid         = 1'b1;
         push.job.is_status = 1'b1;
         push.job.status    = st;
         // Start the next text from scratch.
         held_in  = '0;
         pos_in   = '0;
         pad_in   = '0;
         pdone_in = 1'b0;
         nasc_in  = 1'b0;
         mal_in   = 1'b0;
         count_in = '0;
      end else begin
         st = sb64_pkg::STATUS_OK;
         if (sb64_pkg::is_space(u)) begin
            // Skip whitespace.
         end else if (u[15:7] != 9'd0) begin
            nasc_in = 1'b1;
         end else begin
            if (pos_ff == 2'd0 && pdone_ff)
               mal_in = 1'b1;
            if (!sx[6] && !(is_pad && pos_ff[1]))
               mal_in = 1'b1;
            unique case (pos_ff)
               2'd0: begin
                  pad_in  = 2'd0;
                  held_in = {s, 12'd0};
                  pos_in  = 2'd1;
               end
               2'd1: begin
                  held_in = {held_ff[17:12], s, 6'd0};
                  pos_in  = 2'd2;
               end
               2'd2: begin
                  if (is_pad) begin
                     pad_in[0] = 1'b1;
                     if (held_ff[9:6] != 4'd0)
                        mal_in = 1'b1;
                  end
                  held_in = {held_ff[17:6], s};
                  pos_in  = 2'd3;
               end
               default: begin
                  if (is_pad) begin
                     pad_in[1] = 1'b1;
                     if (!pad3 && c[1:0] != 2'd0)
                        mal_in = 1'b1;
                  end else if (pad3) begin
                     mal_in = 1'b1;
                  end
                  pos_in = 2'd0;
                  if (pad_in != 2'd0)
                     pdone_in = 1'b1;
                  count_in = sum[33] ? {33{1'b1}} : sum[32:0];
                  if (!mal_in && !nasc_ff) begin
                     push.valid      = 1'b1;
                     push.job.bytes  = {a, b, c, s};
                     // Padding in place three only occurs with padding in four here.
                     push.job.nbytes = pad3 ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
                  end
               end
            endcase
         end
      end

      if (!accept) begin
         push     = '0;
         held_in  = held_ff;
         pos_in   = pos_ff;
         pad_in   = pad_ff;
         pdone_in = pdone_ff;
         nasc_in  = nasc_ff;
         mal_in   = mal_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         pos_ff   <= '0;
         pad_ff   <= '0;
         pdone_ff <= 1'b0;
         nasc_ff  <= 1'b0;
         mal_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         pad_ff   <= pad_in;
         pdone_ff <= pdone_in;
         nasc_ff  <= nasc_in;
         mal_ff   <= mal_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/sb64_queue.sv @@
// Job queue between the front end and the byte serializer.
module sb64_queue #(
   parameter int DEPTH = sb64_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sb64_pkg::job_push_type push,
   input  logic                   pop,
   output sb64_pkg::job_type      head,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sb64_pkg::job_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign head      = entries_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!do_push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/sb64_back.sv @@
// Back end: turns queued jobs into one registered result per cycle while ready.
module sb64_back (
   input  logic              clock,
   input  logic              reset,
   input  sb64_pkg::job_type head,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sb64_pkg::rsp_type rsp_payload
);

   logic              valid_ff, valid_in;
   sb64_pkg::rsp_type rsp_ff, rsp_in;
   logic [1:0]        idx_ff, idx_in;
   logic              load;

   assign load        = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = not_empty;
         if (not_empty) begin
            if (head.is_status) begin
               rsp_in.kind      = sb64_pkg::KIND_STATUS;
               rsp_in.data_byte = 8'd0;
               rsp_in.status    = head.status;
               rsp_in.last      = 1'b1;
               pop              = 1'b1;
            end else begin
               rsp_in.kind   = sb64_pkg::KIND_DATA;
               rsp_in.status = sb64_pkg::STATUS_OK;
               rsp_in.last   = 1'b0;
               case (idx_ff)
                  2'd0:    rsp_in.data_byte = head.bytes[23:16];
                  2'd1:    rsp_in.data_byte = head.bytes[15:8];
                  default: rsp_in.data_byte = head.bytes[7:0];
               endcase
               // Advance through the job's bytes, drop it after the last one.
               if (idx_ff == head.nbytes - 2'd1) begin
                  idx_in = 2'd0;
                  pop    = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

@@ rtl/strict_base64_decoder_unit.sv @@
// Strict base64 decoder: one UTF-16 code unit per request, end-of-text request
// closes the text with a status result. A request is taken every cycle while
// the job queue between the front end and the serializer has room; each
// completed quartet free of errors queues one job of one to three bytes, and
// the serializer sends one result per cycle from its output register while
// the result side is ready, so a full-speed text of quartets (three bytes per
// four requests) streams without stalls. The first result of a quartet or the
// status passes the job queue and then the output register. QUEUE_DEPTH sets
// how many jobs can wait while the result side stalls. Bytes stream before a
// late error; discard them when the final status is not ok.
module strict_base64_decoder_unit #(
   parameter int QUEUE_DEPTH = sb64_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sb64_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sb64_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   sb64_pkg::job_push_type push;
   sb64_pkg::job_type      head;
   logic                   not_empty;
   logic                   full;
   logic                   pop;
   logic                   accept;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   sb64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_payload),
      .push        (push)
   );

   sb64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   sb64_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .not_empty   (not_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/sb64_checker.sv @@
// Port-level checks of the strict base64 decoder and their bind.
`include "assert_macros.svh"

module sb64_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sb64_pkg::rsp_type rsp_payload
);

   `SB64_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `SB64_ASSERT_SAME(a_last_is_status, clock, reset, rsp_valid, rsp_payload.last == rsp_payload.kind)
   `SB64_ASSERT_SAME(a_data_status_ok, clock, reset, rsp_valid && rsp_payload.kind == sb64_pkg::KIND_DATA, rsp_payload.status == sb64_pkg::STATUS_OK)
   `SB64_ASSERT_SAME(a_status_shape, clock, reset, rsp_valid && rsp_payload.kind == sb64_pkg::KIND_STATUS, rsp_payload.data_byte == 8'd0 && rsp_payload.status <= sb64_pkg::STATUS_MALFORMED)

endmodule

bind strict_base64_decoder_unit sb64_checker u_sb64_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of the strict base64 decoder unit.
`timescale 1ns / 100ps

module tb_top;

   localparam int RESET_CYCLES = 3;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 50;
   localparam logic [32:0] COUNT_CEILING = 33'h1_FFFF_FFFF;
   localparam logic [15:0] BLANK_UNITS [17] = '{
      16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085, 16'h00A0,
      16'h1680, 16'h2000, 16'h2005, 16'h200A, 16'h2028, 16'h2029, 16'h202F, 16'h205F,
      16'h3000};

   typedef enum {
      FLAW_NONE, FLAW_NON_ASCII, FLAW_BAD_CHAR, FLAW_NOISE, FLAW_EARLY_PAD,
      FLAW_LONE_PAD, FLAW_AFTER_PAD, FLAW_TRUNCATE, FLAW_SPARE_BITS
   } flaw_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sb64_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sb64_pkg::rsp_type rsp_payload;
   logic              csr_wr_en = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   // decoder state as the block should hold it
   logic [31:0]       size_limit;
   logic [17:0]       held_bits;
   logic [1:0]        char_slot;
   logic [1:0]        pad_marks;
   logic              pad_closed;
   logic              saw_non_ascii;
   logic              saw_malformed;
   logic [32:0]       byte_tally;
   sb64_pkg::rsp_type predicted_rsp[$];

   bit idle_on = 1'b1;
   int hold_calls = 0;
   int hold_served = 0;
   int hold_left = 0;
   int rx_gap = 0;
   int error_count = 0;
   int cycle_count = 0;
   int stall_cycles = 0;
   int n_requests = 0;
   int n_texts = 0;
   int n_checked = 0;
   int status_seen[5] = '{default: 0};

   strict_base64_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic is_blank(input logic [15:0] u);
      return u inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
                       [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
                       16'h3000};
   endfunction

   function automatic int sextet_value(input logic [15:0] u);
      if (u >= 16'h0041 && u <= 16'h005A) return int'(u) - 'h41;
      if (u >= 16'h0061 && u <= 16'h007A) return int'(u) - 'h61 + 26;
      if (u >= 16'h0030 && u <= 16'h0039) return int'(u) - 'h30 + 52;
      if (u == 16'h002B) return 62;
      if (u == 16'h002F) return 63;
      return -1;
   endfunction

   function automatic logic [15:0] char_of_sextet(input logic [5:0] v);
      if (v < 6'd26) return 16'h0041 + 16'(v);
      if (v < 6'd52) return 16'h0061 + 16'(v - 6'd26);
      if (v < 6'd62) return 16'h0030 + 16'(v - 6'd52);
      return (v == 6'd62) ? 16'h002B : 16'h002F;
   endfunction

   function automatic int pick_gap();
      if (!idle_on || $urandom_range(0, 1) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic clear_text();
      held_bits = '0;
      char_slot = 2'd0;
      pad_marks = 2'b00;
      pad_closed = 1'b0;
      saw_non_ascii = 1'b0;
      saw_malformed = 1'b0;
      byte_tally = '0;
   endtask

   task automatic push_result(input logic kind, input logic [7:0] b, input logic [2:0] st);
      sb64_pkg::rsp_type r;
      r.kind = kind;
      r.data_byte = b;
      r.status = st;
      r.last = (kind == sb64_pkg::KIND_STATUS);
      predicted_rsp.insert(predicted_rsp.size(), r);
   endtask

   task automatic predict_decode(input sb64_pkg::req_type r);
      logic [15:0] u;
      logic        is_pad;
      logic        pad3;
      int          v;
      logic [5:0]  s, a, b, c;
      logic [33:0] out_size;
      logic [2:0]  st;
      u = r.code_unit;
      if (r.action == sb64_pkg::ACT_END) begin
         // trailing padding does not count toward the decoded size
         out_size = {1'b0, byte_tally};
         if (pad_marks[1]) out_size = out_size - (pad_marks[0] ? 34'd2 : 34'd1);
         if (saw_non_ascii) st = sb64_pkg::STATUS_NON_ASCII;
         else if (char_slot != 2'd0) st = sb64_pkg::STATUS_BAD_LEN;
         else if (out_size > {2'b00, size_limit}) st = sb64_pkg::STATUS_TOO_LARGE;
         else if (saw_malformed) st = sb64_pkg::STATUS_MALFORMED;
         else st = sb64_pkg::STATUS_OK;
         status_seen[st]++;
         push_result(sb64_pkg::KIND_STATUS, 8'h00, st);
         clear_text();
      end else if (!is_blank(u)) begin
         if (u > 16'h007F) begin
            saw_non_ascii = 1'b1;
         end else begin
            is_pad = (u == sb64_pkg::CHAR_PAD);
            v = sextet_value(u);
            s = (v < 0) ? 6'd0 : 6'(v);
            if (char_slot == 2'd0) begin
               pad_marks = 2'b00;
               held_bits = '0;
               if (pad_closed) saw_malformed = 1'b1;
            end
            if (v < 0 && !(is_pad && char_slot >= 2'd2)) saw_malformed = 1'b1;
            case (char_slot)
               2'd0: held_bits[17:12] = s;
               2'd1: held_bits[11:6] = s;
               2'd2: begin
                  if (is_pad) begin
                     pad_marks[0] = 1'b1;
                     if (held_bits[9:6] != 4'd0) saw_malformed = 1'b1;
                  end
                  held_bits[5:0] = s;
               end
               default: begin
                  a = held_bits[17:12];
                  b = held_bits[11:6];
                  c = held_bits[5:0];
                  pad3 = pad_marks[0];
                  if (is_pad) begin
                     pad_marks[1] = 1'b1;
                     if (!pad3 && c[1:0] != 2'b00) saw_malformed = 1'b1;
                  end else if (pad3) begin
                     saw_malformed = 1'b1;
                  end
                  if (pad_marks != 2'b00) pad_closed = 1'b1;
                  byte_tally = (byte_tally > COUNT_CEILING - 33'd3) ? COUNT_CEILING
                                                                     : byte_tally + 33'd3;
                  if (!saw_malformed && !saw_non_ascii) begin
                     push_result(sb64_pkg::KIND_DATA, {a, b[5:4]}, sb64_pkg::STATUS_OK);
                     if (!pad3)
                        push_result(sb64_pkg::KIND_DATA, {b[3:0], c[5:2]},
                                    sb64_pkg::STATUS_OK);
                     if (!is_pad)
                        push_result(sb64_pkg::KIND_DATA, {c[1:0], s}, sb64_pkg::STATUS_OK);
                  end
               end
            endcase
            // the fourth character wraps the slot back to zero
            char_slot = char_slot + 2'd1;
         end
      end
   endtask

   task automatic send_req(input logic act, input logic [15:0] u);
      sb64_pkg::req_type r;
      int                gap;
      r.action = act;
      r.code_unit = u;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_decode(r);
      if (act == sb64_pkg::ACT_END) n_texts++;
      else if (!is_blank(u)) n_requests++;
   endtask

   task automatic send_ascii(input string text);
      for (int i = 0; i < text.len(); i++) send_req(sb64_pkg::ACT_CHAR, {8'h00, text[i]});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      // a character that produces no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_limit(input logic [31:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_limit = value;
   endtask

   task automatic send_random_text();
      logic [15:0] units[$];
      logic [5:0]  sx [4];
      logic [15:0] u;
      logic        last_q;
      flaw_type    flaw;
      int          nq, shape, k, i, pos;
      flaw = FLAW_NONE;
      if ($urandom_range(0, 9) >= 7) flaw = flaw_type'($urandom_range(1, 8));
      nq = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      shape = (nq == 0) ? 0 : $urandom_range(0, 2);
      if (flaw == FLAW_AFTER_PAD && nq > 0) shape = $urandom_range(1, 2);
      for (k = 0; k < nq; k++) begin
         last_q = (k == nq - 1);
         for (i = 0; i < 4; i++) sx[i] = 6'($urandom);
         // keep the spare bits before padding clear unless the flaw wants them set
         if (last_q && shape == 2) sx[1][3:0] = (flaw == FLAW_SPARE_BITS) ? 4'h8 : 4'h0;
         if (last_q && shape == 1) sx[2][1:0] = (flaw == FLAW_SPARE_BITS) ? 2'b10 : 2'b00;
         for (i = 0; i < 4; i++) begin
            u = char_of_sextet(sx[i]);
            if (last_q && i >= 4 - shape) u = sb64_pkg::CHAR_PAD;
            units.insert(units.size(), u);
         end
      end
      case (flaw)
         FLAW_NON_ASCII, FLAW_BAD_CHAR, FLAW_NOISE: begin
            u = (flaw == FLAW_NON_ASCII) ? 16'($urandom_range(16'h0080, 16'hFFFF)) :
                (flaw == FLAW_BAD_CHAR)  ? 16'($urandom_range(0, 16'h007F)) :
                                           16'($urandom);
            units.insert($urandom_range(0, units.size()), u);
         end
         FLAW_EARLY_PAD:
            if (nq > 0)
               units[4 * $urandom_range(0, nq - 1) + $urandom_range(0, 1)] =
                  sb64_pkg::CHAR_PAD;
         FLAW_LONE_PAD:
            if (nq > 0) begin
               pos = 4 * $urandom_range(0, nq - 1);
               units[pos + 2] = sb64_pkg::CHAR_PAD;
               units[pos + 3] = char_of_sextet(6'($urandom));
            end
         FLAW_AFTER_PAD:
            repeat ($urandom_range(1, 4))
               units.insert(units.size(), char_of_sextet(6'($urandom)));
         FLAW_TRUNCATE:
            repeat ($urandom_range(1, 3)) if (units.size() > 0) void'(units.pop_back());
         default: ;
      endcase
      foreach (units[j]) begin
         if ($urandom_range(0, 7) == 0)
            send_req(sb64_pkg::ACT_CHAR, BLANK_UNITS[$urandom_range(0, 16)]);
         send_req(sb64_pkg::ACT_CHAR, units[j]);
      end
      send_req(sb64_pkg::ACT_END, 16'($urandom));
   endtask

   task automatic test_directed_texts();
      send_req(sb64_pkg::ACT_END, 16'hFFFF);
      send_ascii("Zm9v");
      send_req(sb64_pkg::ACT_CHAR, 16'h2000);
      send_req(sb64_pkg::ACT_END, 16'($urandom));
      send_ascii("+/8=");
      send_req(sb64_pkg::ACT_END, 16'($urandom));
   endtask

   task automatic test_directed_errors();
      // non-ASCII outranks the bad length of the lone character
      send_req(sb64_pkg::ACT_CHAR, 16'hFFFF);
      send_ascii("A");
      send_req(sb64_pkg::ACT_END, 16'($urandom));
      send_ascii("=!A=");
      send_req(sb64_pkg::ACT_END, 16'($urandom));
   endtask

   task automatic test_size_limit();
      write_size_limit(32'd0);
      send_ascii("QQ==");
      send_req(sb64_pkg::ACT_END, 16'($urandom));
      send_req(sb64_pkg::ACT_END, 16'($urandom));
   endtask

   task automatic test_random_texts(input logic [31:0] limit, input int n_items);
      int start;
      write_size_limit(limit);
      start = n_requests;
      while (n_requests - start < n_items) send_random_text();
   endtask

   task automatic test_back_pressure();
      wait_drained();
      idle_on = 1'b0;
      hold_calls++;
      // keep offering characters while results pile up behind the held output
      repeat (48) send_req(sb64_pkg::ACT_CHAR, char_of_sextet(6'($urandom)));
      send_req(sb64_pkg::ACT_END, 16'($urandom));
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_calls) begin
         hold_served = hold_calls;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rx_gap = pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      sb64_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_payload), 32'd0);
         end else begin
            want = predicted_rsp.pop_front();
            n_checked++;
            if (rsp_payload.kind !== want.kind)
               report_mismatch("kind", 32'(rsp_payload.kind), 32'(want.kind));
            if (rsp_payload.data_byte !== want.data_byte)
               report_mismatch("data_byte", 32'(rsp_payload.data_byte), 32'(want.data_byte));
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.last !== want.last)
               report_mismatch("last", 32'(rsp_payload.last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready) stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  predicted_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      size_limit = sb64_pkg::MAX_OUTPUT_RESET;
      clear_text();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_texts();
      test_directed_errors();
      test_size_limit();
      test_random_texts(32'hFFFF_FFFF, 45);
      test_random_texts(32'($urandom_range(0, 12)), 45);
      test_back_pressure();
      idle_on = 1'b0;
      test_random_texts(32'($urandom), 35);
      idle_on = 1'b1;
      test_random_texts(sb64_pkg::MAX_OUTPUT_RESET, 45);
      wait_drained();
      $display("Run: %0d texts, %0d non-blank characters, %0d results checked,",
               n_texts, n_requests, n_checked);
      $display("     %0d input stall cycles; status mix ok/non-ASCII/length/large/malformed:",
               stall_cycles);
      $display("     %0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
